// ----- hw/rtl/irpw_pkg.sv -----
// ============================================================================
// Pulse-width IR command sender package
// Shared widths, phase codes and configuration register indexes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package irpw_pkg;

    // Field and register widths
    localparam int CMD_W      = 32;
    localparam int CMD_IDX_W  = $clog2(CMD_W);
    localparam int TIMER_W    = 16;
    localparam int UNIT_W     = 16;
    localparam int HDR_W      = 4;
    localparam int GAP_W      = 20;
    localparam int REP_W      = 4;
    localparam int BITS_W     = 6;
    localparam int ICTR_W     = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int OUT_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_COMPARE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_LENGTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_UNITS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LENGTH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_REPEATS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_FRAME  = 3'd5;

    // Frame phase codes
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_HDR_MARK  = 3'd1;
    localparam logic [2:0] PH_HDR_SPACE = 3'd2;
    localparam logic [2:0] PH_BIT_MARK  = 3'd3;
    localparam logic [2:0] PH_BIT_SPACE = 3'd4;
    localparam logic [2:0] PH_GAP       = 3'd5;

    // One result request
    typedef struct packed {
        logic done_res;
        logic start_rejected;
        logic busy_res;
        logic mark_active;
        logic ir_level;
    } irpw_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ir_pulse_width_command_sender.sv -----
// ============================================================================
// Pulse-width IR command sender
// Sends a command word as carrier-modulated pulse-width frames, one timer
// tick per input request.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

// Each input request is either a timer tick (tuser 0) or a start (tuser 1,
// command in tdata), and each one yields exactly one result request that
// describes the tick just spent. The block takes one request per clock cycle
// unless the result stream stalls, and its result passes through the input
// register, where the frame state advances, and then the output register. A start
// that arrives while a command is still being sent is flagged and ignored.
// Configuration writes are taken at any time and apply from the next tick.
module ir_pulse_width_command_sender (
    input  wire                             aclk,
    input  wire                             aresetn,
    // Configuration write channel
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [irpw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [irpw_pkg::CFG_DATA_W-1:0] cfg_data,
    // Input stream
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire  [irpw_pkg::CMD_W-1:0]      s_axis_tdata,   // [31:0] command
    input  wire                             s_axis_tuser,   // [0] func
    // Result stream
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // [0] ir_level, [1] mark_active, [2] busy_res, [3] start_rejected,
    // [4] done_res, [7:5] zero
    output logic [irpw_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import irpw_pkg::*;

    // Configuration registers
    logic [TIMER_W-1:0] carrier_compare_reg;
    logic [UNIT_W-1:0]  unit_length_reg;
    logic [HDR_W-1:0]   header_units_reg;
    logic [GAP_W-1:0]   gap_length_reg;
    logic [REP_W-1:0]   frame_repeats_reg;
    logic [BITS_W-1:0]  bits_per_frame_reg;

    // Input register
    logic               in_valid_reg;
    logic               in_func_reg;
    logic [CMD_W-1:0]   in_cmd_reg;

    // Frame state
    logic [2:0]         phase_reg, phase_next;
    logic [ICTR_W-1:0]  ictr_reg, ictr_next;
    logic [BITS_W-1:0]  bit_idx_reg, bit_idx_next;
    logic [REP_W-1:0]   rep_idx_reg, rep_idx_next;
    logic [CMD_W-1:0]   held_cmd_reg, held_cmd_next;
    logic [TIMER_W-1:0] car_ctr_reg, car_ctr_next;
    logic               car_lvl_reg, car_lvl_next;

    // Output register
    logic               out_valid_reg;
    irpw_result_t       out_reg, res_next;

    logic               advance;
    logic               cur_bit;
    logic               is_mark;
    logic [ICTR_W-1:0]  raw_len;
    logic [ICTR_W-1:0]  int_len;
    logic               int_end;
    logic [BITS_W-1:0]  bit_inc;
    logic [REP_W-1:0]   rep_inc;
    logic [REP_W-1:0]   rep_max;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - $bits(irpw_result_t)){1'b0}}, out_reg};

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carrier_compare_reg <= 16'd49;
            unit_length_reg     <= 16'd1200;
            header_units_reg    <= 4'd4;
            gap_length_reg      <= 20'd80000;
            frame_repeats_reg   <= 4'd3;
            bits_per_frame_reg  <= 6'd20;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_CARRIER_COMPARE: carrier_compare_reg <= cfg_data[TIMER_W-1:0];
                CFG_UNIT_LENGTH:     unit_length_reg     <= cfg_data[UNIT_W-1:0];
                CFG_HEADER_UNITS:    header_units_reg    <= cfg_data[HDR_W-1:0];
                CFG_GAP_LENGTH:      gap_length_reg      <= cfg_data[GAP_W-1:0];
                CFG_FRAME_REPEATS:   frame_repeats_reg   <= cfg_data[REP_W-1:0];
                CFG_BITS_PER_FRAME:  bits_per_frame_reg  <= cfg_data[BITS_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            in_func_reg <= s_axis_tuser;
            in_cmd_reg  <= s_axis_tdata;
        end
    end

    // Current command bit; positions past the word send zero
    always_comb begin
        if (bit_idx_reg < BITS_W'(CMD_W)) begin
            cur_bit = held_cmd_reg[bit_idx_reg[CMD_IDX_W-1:0]];
        end else begin
            cur_bit = 1'b0;
        end
    end

    // Length of the current interval, at least one tick
    always_comb begin
        unique case (phase_reg)
            PH_HDR_MARK:  raw_len = ICTR_W'(header_units_reg) * ICTR_W'(unit_length_reg);
            PH_BIT_MARK:  raw_len = cur_bit ? ICTR_W'({unit_length_reg, 1'b0})
                                            : ICTR_W'(unit_length_reg);
            PH_HDR_SPACE,
            PH_BIT_SPACE: raw_len = ICTR_W'(unit_length_reg);
            default:      raw_len = gap_length_reg;
        endcase
        int_len = (raw_len == '0) ? ICTR_W'(1) : raw_len;
    end

    assign is_mark = (phase_reg == PH_HDR_MARK) || (phase_reg == PH_BIT_MARK);
    assign int_end = ({1'b0, ictr_reg} + (ICTR_W + 1)'(1)) >= {1'b0, int_len};
    assign bit_inc = bit_idx_reg + BITS_W'(1);
    assign rep_inc = rep_idx_reg + REP_W'(1);
    assign rep_max = (frame_repeats_reg == '0) ? REP_W'(1) : frame_repeats_reg;

    // Next frame state and result for the request in the input register
    always_comb begin
        phase_next    = phase_reg;
        ictr_next     = ictr_reg;
        bit_idx_next  = bit_idx_reg;
        rep_idx_next  = rep_idx_reg;
        held_cmd_next = held_cmd_reg;
        car_ctr_next  = car_ctr_reg;
        car_lvl_next  = car_lvl_reg;
        res_next      = '0;

        priority if (in_func_reg) begin
            // Start request
            res_next.busy_res = 1'b1;
            if (phase_reg != PH_IDLE) begin
                res_next.start_rejected = 1'b1;
            end else begin
                held_cmd_next = in_cmd_reg;
                phase_next    = PH_HDR_MARK;
                ictr_next     = '0;
                bit_idx_next  = '0;
                rep_idx_next  = '0;
                car_ctr_next  = '0;
                car_lvl_next  = 1'b0;
            end
        end else if (phase_reg != PH_IDLE) begin
            // Busy tick: report the tick, then step the carrier and the interval
            res_next.busy_res    = 1'b1;
            res_next.mark_active = is_mark;
            res_next.ir_level    = is_mark && car_lvl_reg;

            if (car_ctr_reg >= carrier_compare_reg) begin
                car_ctr_next = '0;
                if (is_mark) begin
                    car_lvl_next = !car_lvl_reg;
                end
            end else begin
                car_ctr_next = car_ctr_reg + TIMER_W'(1);
            end

            if (int_end) begin
                ictr_next = '0;
                unique case (phase_reg)
                    PH_HDR_MARK: begin
                        phase_next = PH_HDR_SPACE;
                    end
                    PH_HDR_SPACE: begin
                        bit_idx_next = '0;
                        phase_next   = (bits_per_frame_reg != '0) ? PH_BIT_MARK : PH_GAP;
                    end
                    PH_BIT_MARK: begin
                        phase_next = PH_BIT_SPACE;
                    end
                    PH_BIT_SPACE: begin
                        bit_idx_next = bit_inc;
                        phase_next   = (bit_inc < bits_per_frame_reg && bit_inc != '0)
                                       ? PH_BIT_MARK : PH_GAP;
                    end
                    default: begin
                        // End of gap: next repeat or done
                        bit_idx_next = '0;
                        if (rep_inc != '0 && rep_inc < rep_max) begin
                            rep_idx_next = rep_inc;
                            phase_next   = PH_HDR_MARK;
                        end else begin
                            rep_idx_next      = '0;
                            phase_next        = PH_IDLE;
                            res_next.done_res = 1'b1;
                        end
                    end
                endcase
            end else begin
                ictr_next = ictr_reg + ICTR_W'(1);
            end
        end else begin
            // Idle tick: all fields zero
            res_next = '0;
        end
    end

    // Frame state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            ictr_reg     <= '0;
            bit_idx_reg  <= '0;
            rep_idx_reg  <= '0;
            held_cmd_reg <= '0;
            car_ctr_reg  <= '0;
            car_lvl_reg  <= 1'b0;
        end else if (advance) begin
            phase_reg    <= phase_next;
            ictr_reg     <= ictr_next;
            bit_idx_reg  <= bit_idx_next;
            rep_idx_reg  <= rep_idx_next;
            held_cmd_reg <= held_cmd_next;
            car_ctr_reg  <= car_ctr_next;
            car_lvl_reg  <= car_lvl_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_axis_tready) begin
            out_valid_reg <= in_valid_reg;
        end
        if (advance) begin
            out_reg <= res_next;
        end
    end

`ifndef SYNTHESIS
    // An accepted start always begins the header mark
    a_start_enters_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_func_reg && phase_reg == PH_IDLE) |=> (phase_reg == PH_HDR_MARK))
        else $error("accepted start did not enter the header mark");

    // The emitter is only driven during a mark
    a_ir_only_in_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_reg.ir_level && !out_reg.mark_active))
        else $error("ir_level high outside a mark");

    // The final tick leaves the block idle and is reported as busy
    a_done_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res_next.done_res) |=> (phase_reg == PH_IDLE && out_reg.busy_res))
        else $error("done without returning to idle");
`endif

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ============================================================================
// Pulse-width IR command sender testbench
// Drives tick and start requests into the sender and rewrites its registers
// between bursts. An in-bench model of the frame sequencer predicts every
// result, and each returned result is compared field by field. A short
// directed table runs first. Three randomized phases follow, each with its
// own pattern of input gaps and output stalls.
// ============================================================================
`timescale 1ns / 1ps

module tb;

    import irpw_pkg::*;

    // Request kinds carried on tuser
    localparam logic FN_TICK  = 1'b0;
    localparam logic FN_START = 1'b1;

    // Register indexes that the block does not implement
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    // Results that can be read straight off the protocol
    localparam irpw_result_t R_IDLE   = 5'b00000;
    localparam irpw_result_t R_BUSY   = 5'b00100;
    localparam irpw_result_t R_REJECT = 5'b01100;
    localparam irpw_result_t R_DONE   = 5'b10100;

    // Register value patterns for one setting
    localparam int MODE_SMALL = 0;
    localparam int MODE_HIGH  = 1;
    localparam int MODE_LOW   = 2;
    localparam int MODE_ZERO  = 3;

    localparam int PLAN_ROWS = 30;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
        logic                  func;
        logic [CMD_W-1:0]      command;
        logic                  typed;
        irpw_result_t          want;
    } plan_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [CMD_W-1:0]      s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int send_idle_pct = 8;
    int recv_idle_pct = 47;

    // Expected results in request order
    irpw_result_t pending_results[$];

    int n_errors = 0;
    int n_checked = 0;
    int n_requests = 0;
    int n_started = 0;
    int n_refused = 0;
    int n_finished = 0;
    int n_settings = 0;

    // Register copies, reset values
    logic [TIMER_W-1:0] reg_carrier = 16'd49;
    logic [UNIT_W-1:0]  reg_unit = 16'd1200;
    logic [HDR_W-1:0]   reg_header = 4'd4;
    logic [GAP_W-1:0]   reg_gap = 20'd80000;
    logic [REP_W-1:0]   reg_repeats = 4'd3;
    logic [BITS_W-1:0]  reg_bits = 6'd20;

    // Frame sequencer state
    logic [2:0]         fr_phase = PH_IDLE;
    logic [ICTR_W-1:0]  fr_count = '0;
    logic [BITS_W-1:0]  fr_bit = '0;
    logic [REP_W-1:0]   fr_repeat = '0;
    logic [CMD_W-1:0]   fr_word = '0;
    logic [TIMER_W-1:0] car_count = '0;
    logic               car_level = 1'b0;

    plan_row_t directed_plan [PLAN_ROWS];

    ir_pulse_width_command_sender u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Result of one request, and the sequencer step it causes.
    function automatic irpw_result_t sender_response(input logic func,
                                                     input logic [CMD_W-1:0] command);
        irpw_result_t r;
        int unsigned  span;
        logic         bit_one;
        r = R_IDLE;
        if (func == FN_START) begin
            r.busy_res = 1'b1;
            if (fr_phase != PH_IDLE) begin
                r.start_rejected = 1'b1;
                n_refused++;
            end else begin
                fr_word   = command;
                fr_phase  = PH_HDR_MARK;
                fr_count  = '0;
                fr_bit    = '0;
                fr_repeat = '0;
                car_count = '0;
                car_level = 1'b0;
                n_started++;
            end
        end else if (fr_phase != PH_IDLE) begin
            r.busy_res    = 1'b1;
            r.mark_active = (fr_phase == PH_HDR_MARK) || (fr_phase == PH_BIT_MARK);
            r.ir_level    = r.mark_active & car_level;

            // The carrier counter runs on every busy tick but toggles only in a mark.
            if (car_count >= reg_carrier) begin
                car_count = '0;
                if (r.mark_active)
                    car_level = ~car_level;
            end else begin
                car_count = car_count + 1'b1;
            end

            // Lengths are taken live from the registers; zero means one tick.
            bit_one = (fr_bit < CMD_W) ? fr_word[fr_bit[CMD_IDX_W-1:0]] : 1'b0;
            case (fr_phase)
                PH_HDR_MARK: span = 32'(reg_header) * 32'(reg_unit);
                PH_BIT_MARK: span = bit_one ? 32'(reg_unit) << 1 : 32'(reg_unit);
                PH_HDR_SPACE, PH_BIT_SPACE: span = 32'(reg_unit);
                default: span = 32'(reg_gap);
            endcase
            if (span == 0)
                span = 1;

            if (32'(fr_count) + 32'd1 >= span) begin
                fr_count = '0;
                case (fr_phase)
                    PH_HDR_MARK: fr_phase = PH_HDR_SPACE;
                    PH_HDR_SPACE: begin
                        fr_bit   = '0;
                        fr_phase = (reg_bits != 0) ? PH_BIT_MARK : PH_GAP;
                    end
                    PH_BIT_MARK: fr_phase = PH_BIT_SPACE;
                    PH_BIT_SPACE: begin
                        fr_bit   = fr_bit + 1'b1;
                        fr_phase = (fr_bit < reg_bits && fr_bit != 0) ? PH_BIT_MARK : PH_GAP;
                    end
                    default: begin
                        // End of a frame: send it again or finish the command.
                        fr_repeat = fr_repeat + 1'b1;
                        fr_bit    = '0;
                        if (fr_repeat != 0 &&
                            fr_repeat < ((reg_repeats == 0) ? 4'd1 : reg_repeats)) begin
                            fr_phase = PH_HDR_MARK;
                        end else begin
                            fr_phase   = PH_IDLE;
                            fr_repeat  = '0;
                            r.done_res = 1'b1;
                            n_finished++;
                        end
                    end
                endcase
            end else begin
                fr_count = fr_count + 1'b1;
            end
        end
        return r;
    endfunction

    task automatic note_failure(input string what);
        n_errors++;
        if (n_errors <= 10)
            $display("ERROR at %0t: %s", $realtime, what);
    endtask

    // Hold off new requests until every outstanding result has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Leaves cfg_valid high so that back-to-back writes need no dip.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            CFG_CARRIER_COMPARE: reg_carrier = data[TIMER_W-1:0];
            CFG_UNIT_LENGTH:     reg_unit    = data[UNIT_W-1:0];
            CFG_HEADER_UNITS:    reg_header  = data[HDR_W-1:0];
            CFG_GAP_LENGTH:      reg_gap     = data[GAP_W-1:0];
            CFG_FRAME_REPEATS:   reg_repeats = data[REP_W-1:0];
            CFG_BITS_PER_FRAME:  reg_bits    = data[BITS_W-1:0];
            default: ;
        endcase
    endtask

    // One request with an optional lead-in gap; returns the predicted result.
    task automatic send_request(input logic func, input logic [CMD_W-1:0] command,
                                output irpw_result_t predicted);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= command;
        do @(posedge aclk); while (!s_axis_tready);
        n_requests++;
        predicted = sender_response(func, command);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_register(input logic [CFG_IDX_W-1:0] index,
                                                            input int mode);
        logic [CFG_DATA_W-1:0] v;
        int                    w;
        case (index)
            CFG_CARRIER_COMPARE: w = TIMER_W;
            CFG_UNIT_LENGTH:     w = UNIT_W;
            CFG_HEADER_UNITS:    w = HDR_W;
            CFG_GAP_LENGTH:      w = GAP_W;
            CFG_FRAME_REPEATS:   w = REP_W;
            default:             w = BITS_W;
        endcase
        case (mode)
            MODE_HIGH: v = CFG_DATA_W'((64'd1 << w) - 1);
            MODE_LOW:  v = CFG_DATA_W'(1);
            MODE_ZERO: v = '0;
            default: begin
                // Short frames, so that whole commands fit in one burst.
                case (index)
                    CFG_CARRIER_COMPARE:
                        v = ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom_range(65535))
                                                     : CFG_DATA_W'($urandom_range(4));
                    CFG_UNIT_LENGTH:   v = CFG_DATA_W'($urandom_range(2));
                    CFG_HEADER_UNITS:  v = CFG_DATA_W'($urandom_range(5));
                    CFG_GAP_LENGTH:    v = CFG_DATA_W'($urandom_range(6));
                    CFG_FRAME_REPEATS: v = CFG_DATA_W'($urandom_range(3));
                    default:
                        v = (reg_unit <= 1 && $urandom_range(3) == 0) ?
                            CFG_DATA_W'($urandom_range(40, 30)) :
                            CFG_DATA_W'($urandom_range(6));
                endcase
            end
        endcase
        // Junk above the register width must be dropped by the block.
        if (w < CFG_DATA_W && $urandom_range(3) == 0)
            v = v | CFG_DATA_W'($urandom() << w);
        return v;
    endfunction

    // A burst of mostly complete commands with the occasional refused start.
    task automatic drive_commands(input int budget);
        int               spent;
        logic             func;
        logic [CMD_W-1:0] command;
        irpw_result_t     predicted;
        spent = 0;
        while (spent < budget) begin
            case ($urandom_range(9))
                0: command = '0;
                1: command = '1;
                default: command = $urandom();
            endcase
            if (fr_phase == PH_IDLE)
                func = ($urandom_range(9) != 0) ? FN_START : FN_TICK;
            else
                func = ($urandom_range(24) == 0) ? FN_START : FN_TICK;
            if (fr_phase != PH_IDLE || func == FN_START)
                spent++;
            send_request(func, command, predicted);
            pending_results.push_back(predicted);
        end
    endtask

    // Output back-pressure
    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each returned result with the oldest expectation.
    always @(posedge aclk) begin : check_results
        irpw_result_t got;
        irpw_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[4:0];
            if (pending_results.size() == 0) begin
                note_failure($sformatf("result %08b with nothing expected", m_axis_tdata));
            end else begin
                want = pending_results.pop_front();
                if (got.ir_level !== want.ir_level || got.mark_active !== want.mark_active ||
                    got.busy_res !== want.busy_res ||
                    got.start_rejected !== want.start_rejected ||
                    got.done_res !== want.done_res || m_axis_tdata[7:5] !== 3'b000)
                    note_failure($sformatf("result %0d: expected %08b, got %08b",
                                           n_checked, {3'b000, want}, m_axis_tdata));
            end
            n_checked++;
        end
    end

    initial begin : watchdog
        #(12 * 200_000);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        irpw_result_t predicted;
        int           row;
        int           phase_no;
        int           setting;
        int           mode;
        int           r;

        // Directed table: zero-length intervals, zero repeats and zero bits
        // first, then a two-bit command whose repeat count is cut mid-frame.
        directed_plan = '{
            '{ROW_ITEM, 3'd0, 20'd0, FN_TICK, 32'd0, 1'b1, R_IDLE},
            '{ROW_CFG, CFG_CARRIER_COMPARE, 20'd0, FN_TICK, 32'd0, 1'b0, R_IDLE},
            '{ROW_CFG, CFG_UNIT_LENGTH, 20'd0, FN_TICK, 32'd0, 1'b0, R_IDLE},
            '{ROW_CFG, CFG_HEADER_UNITS, 20'd0, FN_TICK, 32'd0, 1'b0, R_IDLE},
            '{ROW_CFG, CFG_GAP_LENGTH, 20'd0, FN_TICK, 32'd0, 1'b0, R_IDLE},
            '{ROW_CFG, CFG_FRAME_REPEATS, 20'd0, FN_TICK, 32'd0, 1'b0, R_IDLE},
            '{ROW_CFG, CFG_BITS_PER_FRAME, 20'd0, FN_TICK, 32'd0, 1'b0, R_IDLE},
            '{ROW_CFG, CFG_SPARE_A, 20'hFFFFF, FN_TICK, 32'd0, 1'b0, R_IDLE},
            '{ROW_CFG, CFG_SPARE_B, 20'hFFFFF, FN_TICK, 32'd0, 1'b0, R_IDLE},
            '{ROW_ITEM, 3'd0, 20'd0, FN_START, 32'hFFFF_FFFF, 1'b1, R_BUSY},
            '{ROW_ITEM, 3'd0, 20'd0, FN_START, 32'h0000_0000, 1'b1, R_REJECT},
            '{ROW_ITEM, 3'd0, 20'd0, FN_TICK, 32'hFFFF_FFFF, 1'b0, R_IDLE},
            '{ROW_ITEM, 3'd0, 20'd0, FN_TICK, 32'd0, 1'b0, R_IDLE},
            '{ROW_ITEM, 3'd0, 20'd0, FN_TICK, 32'd0, 1'b1, R_DONE},
            '{ROW_ITEM, 3'd0, 20'd0, FN_TICK, 32'd0, 1'b1, R_IDLE},
            '{ROW_CFG, CFG_CARRIER_COMPARE, 20'hF0001, FN_TICK, 32'd0, 1'b0, R_IDLE},
            '{ROW_CFG, CFG_HEADER_UNITS, 20'd2, FN_TICK, 32'd0, 1'b0, R_IDLE},
            '{ROW_CFG, CFG_BITS_PER_FRAME, 20'd2, FN_TICK, 32'd0, 1'b0, R_IDLE},
            '{ROW_CFG, CFG_FRAME_REPEATS, 20'd2, FN_TICK, 32'd0, 1'b0, R_IDLE},
            '{ROW_CFG, CFG_GAP_LENGTH, 20'd1, FN_TICK, 32'd0, 1'b0, R_IDLE},
            '{ROW_ITEM, 3'd0, 20'd0, FN_START, 32'h0000_0002, 1'b0, R_IDLE},
            '{ROW_ITEM, 3'd0, 20'd0, FN_TICK, 32'd0, 1'b0, R_IDLE},
            '{ROW_ITEM, 3'd0, 20'd0, FN_TICK, 32'd0, 1'b0, R_IDLE},
            '{ROW_ITEM, 3'd0, 20'd0, FN_TICK, 32'd0, 1'b0, R_IDLE},
            '{ROW_ITEM, 3'd0, 20'd0, FN_TICK, 32'd0, 1'b0, R_IDLE},
            '{ROW_ITEM, 3'd0, 20'd0, FN_TICK, 32'd0, 1'b0, R_IDLE},
            '{ROW_CFG, CFG_FRAME_REPEATS, 20'd1, FN_TICK, 32'd0, 1'b0, R_IDLE},
            '{ROW_ITEM, 3'd0, 20'd0, FN_TICK, 32'd0, 1'b0, R_IDLE},
            '{ROW_ITEM, 3'd0, 20'd0, FN_TICK, 32'd0, 1'b1, R_DONE},
            '{ROW_ITEM, 3'd0, 20'd0, FN_TICK, 32'd0, 1'b1, R_IDLE}
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part
        for (row = 0; row < PLAN_ROWS; row++) begin
            if (directed_plan[row].kind == ROW_CFG) begin
                wait_drained();
                write_register(directed_plan[row].index, directed_plan[row].data);
                if (row + 1 == PLAN_ROWS || directed_plan[row + 1].kind != ROW_CFG)
                    cfg_valid <= 1'b0;
            end else begin
                send_request(directed_plan[row].func, directed_plan[row].command, predicted);
                pending_results.push_back(directed_plan[row].typed ?
                                          directed_plan[row].want : predicted);
            end
        end
        n_settings = 2;

        // Random part: three stall patterns, six register settings each
        for (phase_no = 0; phase_no < 3; phase_no++) begin
            case (phase_no)
                0: begin
                    send_idle_pct = 8;
                    recv_idle_pct = 47;
                end
                1: begin
                    send_idle_pct = 47;
                    recv_idle_pct = 8;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (setting = 0; setting < 6; setting++) begin
                case (setting)
                    1: mode = MODE_HIGH;
                    3: mode = MODE_LOW;
                    4: mode = MODE_ZERO;
                    default: mode = MODE_SMALL;
                endcase
                wait_drained();
                for (r = CFG_CARRIER_COMPARE; r <= CFG_BITS_PER_FRAME; r++)
                    write_register(CFG_IDX_W'(r), pick_register(CFG_IDX_W'(r), mode));
                if ($urandom_range(2) == 0)
                    write_register($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B,
                                   CFG_DATA_W'($urandom()));
                cfg_valid <= 1'b0;
                n_settings++;
                // Huge lengths only get a short burst; the next setting cuts them.
                drive_commands((mode == MODE_HIGH) ? 40 : 120);
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (pending_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_results.size()));

        $display("Sent %0d requests: %0d commands started, %0d starts refused, %0d finished.",
                 n_requests, n_started, n_refused, n_finished);
        $display("Checked %0d results over %0d register settings and three stall patterns.",
                 n_checked, n_settings);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches in total", n_errors);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
